// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the bupt_checker module.
// Each expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define BUPT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("timer port check failed");

// Condition in one cycle requires another condition in the next cycle.
`define BUPT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("timer port sequence check failed");

`endif

// File: hw/rtl/bupt_pkg.sv
package bupt_pkg;

  localparam int unsigned CounterWidth   = 32;
  localparam int unsigned PrescalerWidth = 16;
  localparam int unsigned DataWidth      = 32;

  // Control register bit positions.
  localparam int unsigned CenBit  = 0;
  localparam int unsigned ArpeBit = 7;
  // Single flag bit of the irq enable, status and event generation registers.
  localparam int unsigned LowBit  = 0;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpWrite = 2'd1,
    OpRead  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    RegCtrl     = 3'd0,
    RegIrqEn    = 3'd1,
    RegStatus   = 3'd2,
    RegEventGen = 3'd3,
    RegCount    = 3'd4,
    RegPresc    = 3'd5,
    RegReload   = 3'd6
  } reg_e;

  typedef struct packed {
    logic [1:0]           operation;
    logic [2:0]           reg_select;
    logic [DataWidth-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [DataWidth-1:0] read_data;
    logic                 update_flag;
    logic                 irq;
  } rsp_t;

endpackage

// File: hw/rtl/basic_update_timer_core.sv
// The response to an accepted request is registered in the output register, or in the skid entry.
// Throughput: one request per cycle while the skid entry is empty; a two-entry output buffer
// (output register plus skid) lets one more request in while a response is stalled.
// Reset: all control bits, flags, counters and prescale values clear to zero, the reload
// shadow and active registers set to all ones, and both output entries are emptied.
module basic_update_timer_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bupt_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bupt_pkg::rsp_t out_rsp_o
);

  localparam int unsigned CW = bupt_pkg::CounterWidth;
  localparam int unsigned PW = bupt_pkg::PrescalerWidth;
  localparam int unsigned DW = bupt_pkg::DataWidth;

  // Timer state.
  logic          cen_q, cen_d;
  logic          arpe_q, arpe_d;
  logic          uie_q, uie_d;
  logic          uif_q, uif_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] psc_cnt_q, psc_cnt_d;
  logic [PW-1:0] psc_sh_q, psc_sh_d;
  logic [PW-1:0] psc_act_q, psc_act_d;
  logic [CW-1:0] arr_sh_q, arr_sh_d;
  logic [CW-1:0] arr_act_q, arr_act_d;

  // Output buffer.
  logic           out_valid_q, out_valid_d;
  logic           skid_valid_q, skid_valid_d;
  bupt_pkg::rsp_t out_q, out_d;
  bupt_pkg::rsp_t skid_q, skid_d;

  logic           in_acc;
  logic           out_take;
  logic           upd_evt;
  logic [DW-1:0]  rd_data;
  bupt_pkg::rsp_t rsp;
  bupt_pkg::op_e  op;
  bupt_pkg::reg_e sel;

  assign op       = bupt_pkg::op_e'(in_req_i.operation);
  assign sel      = bupt_pkg::reg_e'(in_req_i.reg_select);
  assign in_stall_o = skid_valid_q;
  assign in_acc   = in_valid_i & ~skid_valid_q;
  assign out_take = out_valid_q & ~out_stall_i;

  // Next timer state for the request at the input.
  always_comb begin
    cen_d     = cen_q;
    arpe_d    = arpe_q;
    uie_d     = uie_q;
    uif_d     = uif_q;
    cnt_d     = cnt_q;
    psc_cnt_d = psc_cnt_q;
    psc_sh_d  = psc_sh_q;
    psc_act_d = psc_act_q;
    arr_sh_d  = arr_sh_q;
    arr_act_d = arr_act_q;
    upd_evt   = 1'b0;
    case (op)
      bupt_pkg::OpTick: begin
        if (cen_q) begin
          if (psc_cnt_q != psc_act_q) begin
            psc_cnt_d = psc_cnt_q + 1'b1;
          end else begin
            psc_cnt_d = '0;
            // A zero reload blocks the counter while the prescaler keeps running.
            if (arr_act_q != '0) begin
              if (cnt_q == arr_act_q) begin
                upd_evt = 1'b1;
              end else begin
                cnt_d = cnt_q + 1'b1;
              end
            end
          end
        end
      end
      bupt_pkg::OpWrite: begin
        case (sel)
          bupt_pkg::RegCtrl: begin
            cen_d  = in_req_i.write_data[bupt_pkg::CenBit];
            arpe_d = in_req_i.write_data[bupt_pkg::ArpeBit];
          end
          bupt_pkg::RegIrqEn: begin
            uie_d = in_req_i.write_data[bupt_pkg::LowBit];
          end
          bupt_pkg::RegStatus: begin
            // The flag is cleared by writing zero; writing one leaves it alone.
            if (!in_req_i.write_data[bupt_pkg::LowBit]) begin
              uif_d = 1'b0;
            end
          end
          bupt_pkg::RegEventGen: begin
            upd_evt = in_req_i.write_data[bupt_pkg::LowBit];
          end
          bupt_pkg::RegCount: begin
            cnt_d = in_req_i.write_data[CW-1:0];
          end
          bupt_pkg::RegPresc: begin
            psc_sh_d = in_req_i.write_data[PW-1:0];
          end
          bupt_pkg::RegReload: begin
            arr_sh_d = in_req_i.write_data[CW-1:0];
            if (!arpe_q) begin
              arr_act_d = in_req_i.write_data[CW-1:0];
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    if (upd_evt) begin
      cnt_d     = '0;
      psc_cnt_d = '0;
      psc_act_d = psc_sh_q;
      arr_act_d = arr_sh_q;
      uif_d     = 1'b1;
    end
  end

  // Read data comes from the state before the request.
  always_comb begin
    rd_data = '0;
    if (op == bupt_pkg::OpRead) begin
      case (sel)
        bupt_pkg::RegCtrl: begin
          rd_data[bupt_pkg::CenBit]  = cen_q;
          rd_data[bupt_pkg::ArpeBit] = arpe_q;
        end
        bupt_pkg::RegIrqEn:  rd_data[bupt_pkg::LowBit] = uie_q;
        bupt_pkg::RegStatus: rd_data[bupt_pkg::LowBit] = uif_q;
        bupt_pkg::RegCount:  rd_data = DW'(cnt_q);
        bupt_pkg::RegPresc:  rd_data = DW'(psc_sh_q);
        bupt_pkg::RegReload: rd_data = DW'(arr_sh_q);
        default:             rd_data = '0;
      endcase
    end
  end

  always_comb begin
    rsp.read_data   = rd_data;
    rsp.update_flag = uif_d;
    rsp.irq         = uif_d & uie_d;
  end

  // The skid entry fills only when the output register is held by a stall.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (in_acc) begin
        out_d       = rsp;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (in_acc) begin
      skid_d       = rsp;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q        <= 1'b0;
      arpe_q       <= 1'b0;
      uie_q        <= 1'b0;
      uif_q        <= 1'b0;
      cnt_q        <= '0;
      psc_cnt_q    <= '0;
      psc_sh_q     <= '0;
      psc_act_q    <= '0;
      arr_sh_q     <= '1;
      arr_act_q    <= '1;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        cen_q     <= cen_d;
        arpe_q    <= arpe_d;
        uie_q     <= uie_d;
        uif_q     <= uif_d;
        cnt_q     <= cnt_d;
        psc_cnt_q <= psc_cnt_d;
        psc_sh_q  <= psc_sh_d;
        psc_act_q <= psc_act_d;
        arr_sh_q  <= arr_sh_d;
        arr_act_q <= arr_act_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// File: hw/rtl/bupt_checker.sv
`include "assert_macros.svh"

module bupt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input bupt_pkg::req_t in_req_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input bupt_pkg::rsp_t out_rsp_o
);

  // Requests accepted whose responses have not yet been taken.
  logic [1:0] pending_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_acc    = out_valid_o & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  `BUPT_ASSERT(a_valid_tracks_pending, out_valid_o == (pending_q != 2'd0))
  `BUPT_ASSERT(a_stall_when_full, in_stall_o == (pending_q == 2'd2))
  `BUPT_ASSERT(a_irq_needs_flag, !out_valid_o || !out_rsp_o.irq || out_rsp_o.update_flag)
  `BUPT_ASSERT_NEXT(a_stalled_rsp_holds, out_valid_o && out_stall_i, out_valid_o && $stable(out_rsp_o))
  `BUPT_ASSERT_NEXT(a_stalled_req_holds, in_valid_i && in_stall_o, in_valid_i && $stable(in_req_i))

endmodule

bind basic_update_timer_core bupt_checker u_bupt_checker (.*);

// File: test/basic_update_timer_checker.sv
module basic_update_timer_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  bupt_pkg::req_t in_req_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  bupt_pkg::rsp_t out_rsp_i,
  output int             fail_count_o,
  output int             pending_o,
  output int             checked_o,
  output int             updates_o
);
  import bupt_pkg::*;

  logic                      cen_q;
  logic                      arpe_q;
  logic                      uie_q;
  logic                      uif_q;
  logic [CounterWidth-1:0]   cnt_q;
  logic [CounterWidth-1:0]   arr_shadow_q;
  logic [CounterWidth-1:0]   arr_active_q;
  logic [PrescalerWidth-1:0] psc_cnt_q;
  logic [PrescalerWidth-1:0] psc_shadow_q;
  logic [PrescalerWidth-1:0] psc_active_q;

  rsp_t timer_rsp_q[$];

  function automatic void timer_update();
    cnt_q        = '0;
    psc_cnt_q    = '0;
    psc_active_q = psc_shadow_q;
    arr_active_q = arr_shadow_q;
    uif_q        = 1'b1;
    updates_o++;
  endfunction

  function automatic rsp_t timer_step(req_t req);
    rsp_t rsp;
    rsp = '0;
    case (req.operation)
      OpTick: begin
        if (cen_q) begin
          if (psc_cnt_q != psc_active_q) begin
            psc_cnt_q++;
          end else begin
            psc_cnt_q = '0;
            // A zero reload value freezes the count while the prescaler keeps running.
            // A count above the reload value runs on to its maximum and wraps silently.
            if (arr_active_q != '0) begin
              if (cnt_q == arr_active_q) timer_update();
              else cnt_q++;
            end
          end
        end
      end
      OpWrite: begin
        case (req.reg_select)
          RegCtrl: begin
            cen_q  = req.write_data[CenBit];
            arpe_q = req.write_data[ArpeBit];
          end
          RegIrqEn: uie_q = req.write_data[LowBit];
          // The flag can only be cleared; writing a one leaves it alone.
          RegStatus: if (!req.write_data[LowBit]) uif_q = 1'b0;
          RegEventGen: if (req.write_data[LowBit]) timer_update();
          RegCount: cnt_q = req.write_data[CounterWidth-1:0];
          RegPresc: psc_shadow_q = req.write_data[PrescalerWidth-1:0];
          RegReload: begin
            arr_shadow_q = req.write_data[CounterWidth-1:0];
            if (!arpe_q) arr_active_q = arr_shadow_q;
          end
          default: ;
        endcase
      end
      OpRead: begin
        case (req.reg_select)
          RegCtrl: begin
            rsp.read_data[CenBit]  = cen_q;
            rsp.read_data[ArpeBit] = arpe_q;
          end
          RegIrqEn: rsp.read_data[LowBit] = uie_q;
          RegStatus: rsp.read_data[LowBit] = uif_q;
          RegCount: rsp.read_data = DataWidth'(cnt_q);
          RegPresc: rsp.read_data = DataWidth'(psc_shadow_q);
          RegReload: rsp.read_data = DataWidth'(arr_shadow_q);
          default: ;
        endcase
      end
      default: ;
    endcase
    rsp.update_flag = uif_q;
    rsp.irq         = uif_q & uie_q;
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rsp_t want;
    if (!rst_ni) begin
      cen_q        = 1'b0;
      arpe_q       = 1'b0;
      uie_q        = 1'b0;
      uif_q        = 1'b0;
      cnt_q        = '0;
      psc_cnt_q    = '0;
      psc_shadow_q = '0;
      psc_active_q = '0;
      arr_shadow_q = '1;
      arr_active_q = '1;
      timer_rsp_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
      updates_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (timer_rsp_q.size() == 0) begin
          $error("response with no request outstanding: read_data %h", out_rsp_i.read_data);
          fail_count_o++;
        end else begin
          want = timer_rsp_q.pop_front();
          checked_o++;
          if (out_rsp_i.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, out_rsp_i.read_data);
            fail_count_o++;
          end
          if (out_rsp_i.update_flag !== want.update_flag) begin
            $error("update_flag: expected %b, got %b", want.update_flag,
                   out_rsp_i.update_flag);
            fail_count_o++;
          end
          if (out_rsp_i.irq !== want.irq) begin
            $error("irq: expected %b, got %b", want.irq, out_rsp_i.irq);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) timer_rsp_q.push_back(timer_step(in_req_i));
    end
    pending_o = timer_rsp_q.size();
  end

endmodule

// File: test/basic_update_timer_core_tb.sv
module basic_update_timer_core_tb;
  import bupt_pkg::*;

  localparam logic [1:0] OpUnused      = 2'd3;
  localparam logic [2:0] RegUnused     = 3'd7;
  localparam int         HoldOffCycles = 300;
  localparam int         PhaseItems    = 500;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_stall_i;
  rsp_t out_rsp_o;

  int fail_count;
  int pending;
  int checked;
  int updates;
  int req_sent;
  int send_idle_pct;
  int rsp_stall_pct;
  int hold_off_seq;

  basic_update_timer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  basic_update_timer_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_i   (out_rsp_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .updates_o   (updates)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("basic_update_timer_core: mismatch");
    $finish;
  end

  // Response side: random stalls, plus a long hold-off each time one is requested.
  initial begin
    int hold_off_seen;
    hold_off_seen = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_seen != hold_off_seq) begin
        hold_off_seen = hold_off_seq;
        for (int i = 0; i < HoldOffCycles; i++) begin
          out_stall_i <= 1'b1;
          @(negedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < rsp_stall_pct);
    end
  end

  function automatic req_t timer_req(input logic [1:0] op, input logic [2:0] sel,
                                     input logic [DataWidth-1:0] data);
    req_t req;
    req.operation  = op;
    req.reg_select = sel;
    req.write_data = data;
    return req;
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_req(input req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    req_sent++;
    @(negedge clk_i);
  endtask

  // Mostly set up a short period and let it run with ticks and register traffic,
  // the rest is unconstrained requests.
  task automatic run_traffic(input int n);
    int stop_at;
    int pick;
    logic [DataWidth-1:0] data;
    stop_at = req_sent + n;
    while (req_sent < stop_at) begin
      if ($urandom_range(99) < 80) begin
        data = $urandom;
        if ($urandom_range(9) != 0) data[CenBit] = 1'b1;
        send_req(timer_req(OpWrite, RegCtrl, data));
        data = $urandom;
        data[PrescalerWidth-1:0] = PrescalerWidth'($urandom_range(0, 3));
        send_req(timer_req(OpWrite, RegPresc, data));
        send_req(timer_req(OpWrite, RegReload, $urandom_range(0, 12)));
        if ($urandom_range(5) == 0) data = '1 - $urandom_range(0, 6);
        else data = $urandom_range(0, 5);
        send_req(timer_req(OpWrite, RegCount, data));
        data = $urandom;
        if ($urandom_range(3) != 0) data[LowBit] = 1'b1;
        send_req(timer_req(OpWrite, RegEventGen, data));
        repeat ($urandom_range(10, 60)) begin
          pick = $urandom_range(99);
          if (pick < 70) begin
            send_req(timer_req(OpTick, 3'($urandom_range(0, 7)), $urandom));
          end else if (pick < 85) begin
            send_req(timer_req(OpRead, 3'($urandom_range(0, 7)), $urandom));
          end else if (pick < 91) begin
            send_req(timer_req(OpWrite, RegStatus, $urandom));
          end else if (pick < 95) begin
            send_req(timer_req(OpWrite, RegIrqEn, $urandom));
          end else if (pick < 97) begin
            data = $urandom;
            data[CenBit] = 1'b1;
            send_req(timer_req(OpWrite, RegCtrl, data));
          end else if (pick < 99) begin
            send_req(timer_req(OpWrite, RegReload, $urandom_range(0, 12)));
          end else begin
            send_req(timer_req(OpWrite, RegEventGen, $urandom));
          end
        end
      end else begin
        repeat ($urandom_range(1, 5))
          send_req(timer_req(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                             $urandom));
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_req_i      = '0;
    req_sent      = 0;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_off_seq  = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset values, the unused operation and register, a frozen counter at reload zero.
    send_req(timer_req(OpRead, RegReload, '0));
    send_req(timer_req(OpUnused, RegCtrl, '1));
    send_req(timer_req(OpRead, RegUnused, '0));
    send_req(timer_req(OpWrite, RegIrqEn, '1));
    send_req(timer_req(OpWrite, RegCtrl, 1 << CenBit));
    send_req(timer_req(OpWrite, RegReload, '0));
    repeat (2) send_req(timer_req(OpTick, RegCtrl, '0));
    send_req(timer_req(OpRead, RegCount, '0));
    // Masked prescaler write that waits for the next update to become active.
    send_req(timer_req(OpWrite, RegPresc, '1));
    send_req(timer_req(OpRead, RegPresc, '0));
    // Count above reload wraps through zero, then hits reload and updates.
    send_req(timer_req(OpWrite, RegReload, 3));
    send_req(timer_req(OpWrite, RegCount, '1 - 1));
    repeat (6) send_req(timer_req(OpTick, RegCtrl, '0));
    send_req(timer_req(OpWrite, RegStatus, 1 << LowBit));
    send_req(timer_req(OpWrite, RegStatus, '0));
    // With preload on, a reload write waits for the forced update.
    send_req(timer_req(OpWrite, RegPresc, 2));
    send_req(timer_req(OpWrite, RegCtrl, '1));
    send_req(timer_req(OpWrite, RegReload, 7));
    send_req(timer_req(OpWrite, RegEventGen, 1 << LowBit));

    hold_off_seq++;
    run_traffic(PhaseItems);
    send_idle_pct = 72;
    run_traffic(PhaseItems);
    send_idle_pct = 0;
    rsp_stall_pct = 72;
    run_traffic(PhaseItems);
    send_idle_pct = 18;
    rsp_stall_pct = 18;
    run_traffic(PhaseItems);
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    $display("Sent %0d requests and checked %0d responses across four idle/stall mixes,",
             req_sent, checked);
    $display("including one long output hold-off; %0d update events occurred.", updates);
    if (fail_count == 0) begin
      $display("basic_update_timer_core: match");
    end else begin
      $display("basic_update_timer_core: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/bupt_pkg.sv
hw/rtl/basic_update_timer_core.sv
hw/rtl/bupt_checker.sv
test/basic_update_timer_checker.sv
test/basic_update_timer_core_tb.sv
